### hw/rtl/vkd_pkg.sv
// Shared types and codes of the value keyed deque.
`default_nettype none
package vkd_pkg;

	typedef enum logic [2:0] {
		FN_PUSH_BACK  = 3'd0,
		FN_POP_BACK   = 3'd1,
		FN_PUSH_FRONT = 3'd2,
		FN_POP_FRONT  = 3'd3,
		FN_INSERT     = 3'd4,
		FN_DELETE     = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic    load;
		logic    set_status;
		status_t status;
		logic    push_back;
		logic    pop_back;
		logic    push_front;
		logic    pop_front;
		logic    scan_start;
		logic    scan;
		logic    hit;
		logic    shift_start;
		logic    shift;
		logic    finish_ins;
		logic    finish_del;
		logic    rd_front;
		logic    rd_back;
		logic    cap_front;
		logic    cap_back;
		logic    emit;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;
		logic  full;
		logic  empty;
		logic  hit;
		logic  miss;
		logic  at_zero;
		logic  shift_done;
		logic  out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

### hw/rtl/value_keyed_deque_unit.sv
// Flow: a refused request or an unused code goes from decode straight to the result.
// Push and pop at either end update the ring, then reread the cached front and back values.
// A key that is not found is sought through every entry; a key match at the front pushes or
// pops there, else the entries shift through the single read port of the entry RAM.
// Throughput: one request at a time; the next transfer is taken once the result is registered.
// Reset: arst_n clears the count, front pointer and state; the entry RAM is not cleared.
`default_nettype none
module value_keyed_deque_unit #(
	parameter int DEPTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// request side
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [2:0]   s_tuser,   // [2:0] func
	input  wire logic [63:0]  s_tdata,   // [31:0] value, [63:32] key
	// result side
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [1:0]        m_tuser,   // [1:0] status
	output logic [103:0]      m_tdata    // [31:0] removed_value, [63:32] front_value,
	                                     // [95:64] back_value, [100:96] entry_count
);
	import vkd_pkg::*;

	dp_cmd_t            cmd;
	dp_sts_t            sts;
	logic [1:0]         out_status;
	logic signed [31:0] out_removed, out_front, out_back;
	logic [4:0]         out_count;

	// Sequencer: decode, key scan, shift walk, then refresh the cached end values.
	vkd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Ring storage, pointers and the output register.
	vkd_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_func     (s_tuser),
		.in_value    (s_tdata[31:0]),
		.in_key      (s_tdata[63:32]),
		.cmd         (cmd),
		.sts         (sts),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.out_status  (out_status),
		.out_removed (out_removed),
		.out_front   (out_front),
		.out_back    (out_back),
		.out_count   (out_count)
	);

	// Pack the result fields, lowest field first, padded to whole bytes.
	assign m_tuser = out_status;
	assign m_tdata = {3'b000, out_count, out_back, out_front, out_removed};
endmodule
`default_nettype wire

### hw/rtl/vkd_ram.sv
// Generic single write, single read RAM with registered read data.
`default_nettype none
module vkd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                      wr_data,
	input  wire logic                                  rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                      rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

### hw/rtl/vkd_ctrl.sv
// Controller state machine of the value keyed deque.
`default_nettype none
module vkd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire vkd_pkg::dp_sts_t sts,
	output vkd_pkg::dp_cmd_t      cmd
);
	import vkd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SCAN, S_ACT, S_SHIFT, S_REF_F, S_REF_B, S_REF_C, S_DONE
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				case (sts.func)
					FN_PUSH_BACK: begin
						if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
						end else begin
							cmd.push_back = 1'b1;
							state_d       = S_REF_F;
						end
					end
					FN_POP_BACK: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
						end else begin
							cmd.pop_back = 1'b1;
							state_d      = S_REF_F;
						end
					end
					FN_PUSH_FRONT: begin
						if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
						end else begin
							cmd.push_front = 1'b1;
							state_d        = S_REF_F;
						end
					end
					FN_POP_FRONT: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
						end else begin
							cmd.pop_front = 1'b1;
							state_d       = S_REF_F;
						end
					end
					FN_INSERT: begin
						if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
						end else if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_NOT_FOUND;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					FN_DELETE: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_SCAN: begin
				if (sts.hit) begin
					cmd.hit = 1'b1;
					state_d = S_ACT;
				end else if (sts.miss) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_NOT_FOUND;
					state_d        = S_DONE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_ACT: begin
				if (sts.at_zero) begin
					if (sts.func == FN_INSERT) begin
						cmd.push_front = 1'b1;
					end else begin
						cmd.pop_front = 1'b1;
					end
					state_d = S_REF_F;
				end else begin
					cmd.shift_start = 1'b1;
					state_d         = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (sts.shift_done) begin
					if (sts.func == FN_INSERT) begin
						cmd.finish_ins = 1'b1;
					end else begin
						cmd.finish_del = 1'b1;
					end
					state_d = S_REF_F;
				end else begin
					cmd.shift = 1'b1;
				end
			end
			S_REF_F: begin
				cmd.rd_front = 1'b1;
				state_d      = S_REF_B;
			end
			S_REF_B: begin
				cmd.cap_front = 1'b1;
				cmd.rd_back   = 1'b1;
				state_d       = S_REF_C;
			end
			S_REF_C: begin
				cmd.cap_back = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

### hw/rtl/vkd_datapath.sv
// Datapath of the value keyed deque: ring pointers, entry RAM, scan and shift engine.
`default_nettype none
module vkd_datapath #(
	parameter int DEPTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [2:0]          in_func,
	input  wire logic signed [31:0]  in_value,
	input  wire logic signed [31:0]  in_key,
	input  wire vkd_pkg::dp_cmd_t    cmd,
	output vkd_pkg::dp_sts_t         sts,
	input  wire logic                m_tready,
	output logic                     m_tvalid,
	output logic [1:0]               out_status,
	output logic signed [31:0]       out_removed,
	output logic signed [31:0]       out_front,
	output logic signed [31:0]       out_back,
	output logic [4:0]               out_count
);
	import vkd_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
			input logic [CW-1:0] pos);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(pos);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	func_t              func_q;
	logic signed [31:0] value_q, key_q;
	logic [AW-1:0]      front_idx_q;
	logic [CW-1:0]      count_q;
	logic signed [31:0] front_val_q, back_val_q, removed_q;
	status_t            status_q;
	logic [CW-1:0]      rd_ptr_q, cmp_pos_q, at_q;
	logic               cmp_vld_q;
	logic [CW-1:0]      sh_rd_q, sh_left_q, sh_wr_pos_q;
	logic               sh_wr_vld_q;

	logic [AW-1:0]      dec_front, inc_front;
	logic [CW-1:0]      last_pos;
	logic               rd_en, wr_en;
	logic [AW-1:0]      rd_addr, wr_addr;
	logic [31:0]        wr_data, rd_data;
	logic               is_insert;

	assign dec_front = (front_idx_q == '0) ? LAST_IDX : front_idx_q - 1'b1;
	assign inc_front = (front_idx_q == LAST_IDX) ? '0 : front_idx_q + 1'b1;
	assign last_pos  = (count_q == '0) ? '0 : count_q - 1'b1;
	assign is_insert = (func_q == FN_INSERT);

	// RAM port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = front_idx_q;
		wr_en   = 1'b0;
		wr_addr = slot(front_idx_q, count_q);
		wr_data = value_q;
		if (cmd.scan && rd_ptr_q != count_q) begin
			rd_en   = 1'b1;
			rd_addr = slot(front_idx_q, rd_ptr_q);
		end
		if (cmd.shift && sh_left_q != '0) begin
			rd_en   = 1'b1;
			rd_addr = slot(front_idx_q, sh_rd_q);
		end
		if (cmd.shift && sh_wr_vld_q) begin
			wr_en   = 1'b1;
			wr_addr = slot(front_idx_q, sh_wr_pos_q);
			wr_data = rd_data;
		end
		if (cmd.rd_front) begin
			rd_en   = 1'b1;
			rd_addr = front_idx_q;
		end
		if (cmd.rd_back) begin
			rd_en   = 1'b1;
			rd_addr = slot(front_idx_q, last_pos);
		end
		if (cmd.push_back) begin
			wr_en   = 1'b1;
			wr_addr = slot(front_idx_q, count_q);
			wr_data = value_q;
		end
		if (cmd.push_front) begin
			wr_en   = 1'b1;
			wr_addr = dec_front;
			wr_data = value_q;
		end
		if (cmd.finish_ins) begin
			wr_en   = 1'b1;
			wr_addr = slot(front_idx_q, at_q);
			wr_data = value_q;
		end
	end

	vkd_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		sts.func       = func_q;
		sts.full       = (count_q == FULL_CNT);
		sts.empty      = (count_q == '0);
		sts.hit        = cmp_vld_q && (rd_data == key_q);
		sts.miss       = !cmp_vld_q && (rd_ptr_q == count_q);
		sts.at_zero    = (at_q == '0);
		sts.shift_done = (sh_left_q == '0) && !sh_wr_vld_q;
		sts.out_free   = !m_tvalid || m_tready;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_idx_q <= '0;
			count_q     <= '0;
			cmp_vld_q   <= 1'b0;
			sh_wr_vld_q <= 1'b0;
			m_tvalid    <= 1'b0;
		end else begin
			if (cmd.push_back || cmd.finish_ins) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.push_front) begin
				front_idx_q <= dec_front;
				count_q     <= count_q + 1'b1;
			end
			if (cmd.pop_back || cmd.finish_del) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.pop_front) begin
				front_idx_q <= inc_front;
				count_q     <= count_q - 1'b1;
			end
			if (cmd.scan_start) begin
				cmp_vld_q <= 1'b0;
			end else if (cmd.scan) begin
				cmp_vld_q <= (rd_ptr_q != count_q);
			end
			if (cmd.shift_start) begin
				sh_wr_vld_q <= 1'b0;
			end else if (cmd.shift) begin
				sh_wr_vld_q <= (sh_left_q != '0);
			end
			if (cmd.emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q    <= func_t'(in_func);
			value_q   <= in_value;
			key_q     <= in_key;
			removed_q <= '0;
			status_q  <= ST_OK;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.pop_back) begin
			removed_q <= back_val_q;
		end
		if (cmd.pop_front) begin
			removed_q <= front_val_q;
		end
		if (cmd.scan_start) begin
			rd_ptr_q <= '0;
		end else if (cmd.scan && rd_ptr_q != count_q) begin
			rd_ptr_q  <= rd_ptr_q + 1'b1;
			cmp_pos_q <= rd_ptr_q;
		end
		if (cmd.hit) begin
			at_q <= cmp_pos_q;
			if (func_q == FN_DELETE) begin
				removed_q <= rd_data;
			end
		end
		if (cmd.shift_start) begin
			if (is_insert) begin
				sh_rd_q   <= count_q - 1'b1;
				sh_left_q <= count_q - at_q;
			end else begin
				sh_rd_q   <= at_q + 1'b1;
				sh_left_q <= count_q - at_q - 1'b1;
			end
		end else if (cmd.shift && sh_left_q != '0) begin
			sh_left_q <= sh_left_q - 1'b1;
			if (is_insert) begin
				sh_rd_q     <= sh_rd_q - 1'b1;
				sh_wr_pos_q <= sh_rd_q + 1'b1;
			end else begin
				sh_rd_q     <= sh_rd_q + 1'b1;
				sh_wr_pos_q <= sh_rd_q - 1'b1;
			end
		end
		if (cmd.cap_front) begin
			front_val_q <= rd_data;
		end
		if (cmd.cap_back) begin
			back_val_q <= rd_data;
		end
		if (cmd.emit) begin
			out_status  <= status_q;
			out_removed <= removed_q;
			out_front   <= (count_q == '0) ? '0 : front_val_q;
			out_back    <= (count_q == '0) ? '0 : back_val_q;
			out_count   <= 5'(count_q);
		end
	end
endmodule
`default_nettype wire
